FILE: hw/rtl/asl_pkg.sv
// Shared types, token codes, keyword table and character class helpers for the line lexer.
package asl_pkg;

    typedef struct packed {
        logic [7:0] ch;
        logic       line_end;
    } char_item_t;

    typedef struct packed {
        logic [5:0] token_type;
        logic [7:0] start_col;
        logic [6:0] token_len;
        logic       end_of_line;
        logic [5:0] tokens_on_line;
        logic       overflow;
    } token_item_t;

    // Up to two results per character; first is queued ahead of second.
    typedef struct packed {
        logic [1:0]  count;
        token_item_t first;
        token_item_t second;
    } token_push_t;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_DIGITS,
        MODE_SIGNED,
        MODE_DIR,
        MODE_STRING,
        MODE_SKIP
    } lex_mode_t;

    typedef struct packed {
        logic       hit;
        logic [5:0] code;
    } kw_match_t;

    localparam logic [5:0] TT_NONE  = 6'd0;
    localparam logic [5:0] TT_HASH  = 6'd28;
    localparam logic [5:0] TT_INT   = 6'd29;
    localparam logic [5:0] TT_STR   = 6'd30;
    localparam logic [5:0] TT_ERR   = 6'd31;
    localparam logic [5:0] TT_LDEF  = 6'd32;
    localparam logic [5:0] TT_LUSE  = 6'd33;
    localparam logic [5:0] TT_COMMA = 6'd34;
    localparam logic [5:0] TT_STAR  = 6'd35;

    localparam int KW_COUNT = 28;

    // Keyword text right-justified: the last character sits in the low byte.
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'("r0"), 64'("r1"), 64'("r2"), 64'("r3"),
        64'("r4"), 64'("r5"), 64'("r6"), 64'("r7"),
        64'("mov"), 64'("cmp"), 64'("add"), 64'("sub"),
        64'("not"), 64'("clr"), 64'("lea"), 64'("inc"),
        64'("dec"), 64'("jmp"), 64'("bne"), 64'("red"),
        64'("prn"), 64'("jsr"), 64'("rts"), 64'("stop"),
        64'(".data"), 64'(".string"), 64'(".entry"), 64'(".extern")
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
        3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4,
        3'd5, 3'd7, 3'd6, 3'd7
    };

    localparam int OFIFO_DEPTH = 4;
    localparam int OFIFO_AW    = 2;
    localparam int OFIFO_CW    = 3;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_print(input logic [7:0] c);
        return (c >= 8'h20) && (c <= 8'h7E);
    endfunction

    // Parallel compare of the held head characters against every keyword.
    function automatic kw_match_t kw_lookup(input logic [7:0][7:0] head,
                                            input logic [6:0] len);
        kw_match_t res;
        logic      same;
        res = '0;
        for (int i = 0; i < KW_COUNT; i++)
        begin
            same = (len == {4'd0, KW_LEN[i]});
            for (int k = 0; k < 8; k++)
            begin
                if (k < int'(KW_LEN[i]))
                begin
                    if (head[k] != KW_TEXT[i][(int'(KW_LEN[i]) - 1 - k) * 8 +: 8])
                    begin
                        same = 1'b0;
                    end
                end
            end
            if (same)
            begin
                res.hit  = 1'b1;
                res.code = 6'(i);
            end
        end
        return res;
    endfunction

endpackage

FILE: hw/rtl/asl_lexer.sv
// Lexer state and single-pass token classification for one registered character.
module asl_lexer #(
    parameter int MAX_TOKEN_CHARS = 80,
    parameter int MAX_LINE_TOKENS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  asl_pkg::char_item_t item,
    output asl_pkg::token_push_t push
);

    localparam logic [6:0] RUN_CAP   = 7'(MAX_TOKEN_CHARS - 1);
    localparam logic [5:0] TOK_BOUND = 6'(MAX_LINE_TOKENS);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_STAR  = 8'h2A;

    asl_pkg::lex_mode_t mode_reg, mode_next;
    logic [7:0][7:0]    head_reg;
    logic [6:0]         run_len_reg, run_len_next;
    logic [7:0]         run_start_reg, run_start_next;
    logic [7:0]         column_reg, column_next;
    logic [7:0]         last_char_reg, last_char_next;
    logic [5:0]         tokens_reg, tokens_next;
    logic               too_many_reg, too_many_next;

    logic [7:0]         c;
    logic               take;
    logic               extend;
    logic               in_run;
    logic               append_en;
    logic               ldef_en;
    logic               close_en;
    logic               start_en;
    logic               sym_en;
    asl_pkg::lex_mode_t start_mode;
    logic [5:0]         sym_type;
    logic [5:0]         close_type;
    asl_pkg::kw_match_t kw;
    logic               a_en, a_push, b_push, sym_push;
    logic [5:0]         tokens_a, tokens_b;
    logic               tm_a, tm_b;
    asl_pkg::token_item_t a_item, b_item;
    logic               head_we;
    logic [2:0]         head_addr;

    assign c  = item.ch;
    assign kw = asl_pkg::kw_lookup(head_reg, run_len_reg);

    always_comb
    begin
        unique case (mode_reg)
            asl_pkg::MODE_WORD:   take = asl_pkg::is_digit(c) || asl_pkg::is_alpha(c);
            asl_pkg::MODE_DIGITS: take = asl_pkg::is_digit(c);
            asl_pkg::MODE_SIGNED: take = asl_pkg::is_digit(c);
            asl_pkg::MODE_DIR:    take = asl_pkg::is_alpha(c);
            asl_pkg::MODE_STRING: take = asl_pkg::is_print(c);
            default:              take = 1'b0;
        endcase
    end

    assign in_run = (mode_reg != asl_pkg::MODE_IDLE) && (mode_reg != asl_pkg::MODE_SKIP);
    assign extend = take && (run_len_reg < RUN_CAP);

    assign append_en = step && !item.line_end && in_run && extend;
    assign ldef_en   = step && !item.line_end && (mode_reg == asl_pkg::MODE_WORD)
                       && !extend && (c == CH_COLON);
    assign close_en  = step && in_run && (item.line_end || (!extend && !ldef_en));
    assign start_en  = step && !item.line_end && (mode_reg != asl_pkg::MODE_SKIP)
                       && !append_en && !ldef_en;

    // What a character starts when no run absorbs it.
    always_comb
    begin
        sym_en     = 1'b0;
        start_mode = asl_pkg::MODE_IDLE;
        priority if ((c == CH_NUL) || (c == CH_SEMI))
            start_mode = asl_pkg::MODE_SKIP;
        else if (asl_pkg::is_space(c))
            start_mode = asl_pkg::MODE_IDLE;
        else if (c == CH_QUOTE)
            start_mode = asl_pkg::MODE_STRING;
        else if ((c == CH_PLUS) || (c == CH_MINUS))
            start_mode = asl_pkg::MODE_SIGNED;
        else if (c == CH_DOT)
            start_mode = asl_pkg::MODE_DIR;
        else if (asl_pkg::is_alpha(c))
            start_mode = asl_pkg::MODE_WORD;
        else if (asl_pkg::is_digit(c))
            start_mode = asl_pkg::MODE_DIGITS;
        else
            sym_en = start_en;
    end

    always_comb
    begin
        priority if (c == CH_HASH)
            sym_type = asl_pkg::TT_HASH;
        else if (c == CH_COMMA)
            sym_type = asl_pkg::TT_COMMA;
        else if (c == CH_STAR)
            sym_type = asl_pkg::TT_STAR;
        else if (c == CH_COLON)
            sym_type = asl_pkg::TT_LDEF;
        else
            sym_type = asl_pkg::TT_ERR;
    end

    always_comb
    begin
        unique case (mode_reg)
            asl_pkg::MODE_WORD:   close_type = kw.hit ? kw.code : asl_pkg::TT_LUSE;
            asl_pkg::MODE_DIGITS: close_type = asl_pkg::TT_INT;
            asl_pkg::MODE_SIGNED: close_type = (run_len_reg > 7'd1) ? asl_pkg::TT_INT
                                                                    : asl_pkg::TT_ERR;
            asl_pkg::MODE_DIR:    close_type = kw.hit ? kw.code : asl_pkg::TT_ERR;
            asl_pkg::MODE_STRING: close_type = (last_char_reg == CH_QUOTE) ? asl_pkg::TT_STR
                                                                           : asl_pkg::TT_ERR;
            default:              close_type = asl_pkg::TT_ERR;
        endcase
    end

    // First result: the closed run or a label definition; past the bound it only flags.
    always_comb
    begin
        a_en     = close_en || ldef_en;
        a_push   = a_en && (tokens_reg < TOK_BOUND);
        tokens_a = a_push ? tokens_reg + 6'd1 : tokens_reg;
        tm_a     = too_many_reg || (a_en && !a_push);

        a_item.token_type     = ldef_en ? asl_pkg::TT_LDEF : close_type;
        a_item.start_col      = run_start_reg;
        a_item.token_len      = run_len_reg;
        a_item.end_of_line    = 1'b0;
        a_item.tokens_on_line = tokens_a;
        a_item.overflow       = too_many_reg;

        sym_push = sym_en && (tokens_a < TOK_BOUND);
        tokens_b = sym_push ? tokens_a + 6'd1 : tokens_a;
        tm_b     = tm_a || (sym_en && !sym_push);

        if (item.line_end)
        begin
            b_item.token_type     = asl_pkg::TT_NONE;
            b_item.start_col      = 8'd0;
            b_item.token_len      = 7'd0;
            b_item.end_of_line    = 1'b1;
            b_item.tokens_on_line = tokens_a;
            b_item.overflow       = tm_a;
        end
        else
        begin
            b_item.token_type     = sym_type;
            b_item.start_col      = column_reg;
            b_item.token_len      = 7'd1;
            b_item.end_of_line    = 1'b0;
            b_item.tokens_on_line = tokens_b;
            b_item.overflow       = tm_a;
        end
        b_push = (step && item.line_end) || sym_push;

        push.count  = {1'b0, a_push} + {1'b0, b_push};
        push.first  = a_push ? a_item : b_item;
        push.second = b_item;
    end

    always_comb
    begin
        mode_next      = mode_reg;
        run_len_next   = run_len_reg;
        run_start_next = run_start_reg;
        column_next    = column_reg;
        last_char_next = last_char_reg;
        tokens_next    = tokens_reg;
        too_many_next  = too_many_reg;
        head_we        = 1'b0;
        head_addr      = run_len_reg[2:0];
        if (step)
        begin
            if (item.line_end)
            begin
                mode_next      = asl_pkg::MODE_IDLE;
                run_len_next   = 7'd0;
                run_start_next = 8'd0;
                column_next    = 8'd0;
                last_char_next = 8'd0;
                tokens_next    = 6'd0;
                too_many_next  = 1'b0;
            end
            else
            begin
                if (column_reg != 8'hFF)
                    column_next = column_reg + 8'd1;
                tokens_next   = tokens_b;
                too_many_next = tm_b;
                if (append_en)
                begin
                    run_len_next   = run_len_reg + 7'd1;
                    last_char_next = c;
                    head_we        = (run_len_reg < 7'd8);
                end
                else if (ldef_en)
                begin
                    mode_next = asl_pkg::MODE_IDLE;
                end
                else if (start_en)
                begin
                    mode_next = start_mode;
                    if ((start_mode != asl_pkg::MODE_IDLE)
                        && (start_mode != asl_pkg::MODE_SKIP))
                    begin
                        run_start_next = column_reg;
                        run_len_next   = 7'd1;
                        last_char_next = c;
                        head_we        = 1'b1;
                        head_addr      = 3'd0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= asl_pkg::MODE_IDLE;
            run_len_reg   <= 7'd0;
            run_start_reg <= 8'd0;
            column_reg    <= 8'd0;
            last_char_reg <= 8'd0;
            tokens_reg    <= 6'd0;
            too_many_reg  <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            run_len_reg   <= run_len_next;
            run_start_reg <= run_start_next;
            column_reg    <= column_next;
            last_char_reg <= last_char_next;
            tokens_reg    <= tokens_next;
            too_many_reg  <= too_many_next;
        end
    end

    // Only positions already written for the current run can affect a keyword match.
    always_ff @(posedge clk)
    begin
        if (head_we)
            head_reg[head_addr] <= c;
    end

endmodule

FILE: hw/rtl/asl_out_fifo.sv
// Four-entry result queue taking up to two results per cycle and issuing one per transfer.
module asl_out_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  asl_pkg::token_push_t  push,
    output logic                  room,
    output logic                  token_valid,
    input  logic                  token_stall,
    output asl_pkg::token_item_t  token_item
);

    asl_pkg::token_item_t            mem_reg [asl_pkg::OFIFO_DEPTH];
    logic [asl_pkg::OFIFO_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [asl_pkg::OFIFO_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [asl_pkg::OFIFO_CW-1:0]    count_reg, count_next;
    logic [asl_pkg::OFIFO_AW-1:0]    wr_ptr_plus1;
    logic                            pop;

    assign token_valid  = (count_reg != '0);
    assign token_item   = mem_reg[rd_ptr_reg];
    assign pop          = token_valid && !token_stall;
    assign room         = (count_reg <= asl_pkg::OFIFO_CW'(asl_pkg::OFIFO_DEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + asl_pkg::OFIFO_AW'(1);

    always_comb
    begin
        rd_ptr_next = pop ? rd_ptr_reg + asl_pkg::OFIFO_AW'(1) : rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg + asl_pkg::OFIFO_AW'(push.count);
        count_next  = count_reg + asl_pkg::OFIFO_CW'(push.count)
                      - asl_pkg::OFIFO_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem_reg[wr_ptr_plus1] <= push.second;
    end

endmodule

FILE: hw/rtl/assembly_line_lexer_core.sv
// Top level of the assembly line lexer: input register, lexer stage and result queue.
//
// Characters arrive on the char channel (char_valid / char_stall / char_item), one per
// transfer; an item with line_end set closes the line. Tokens leave on the token channel
// (token_valid / token_stall / token_item), one result per transfer, each with its type
// code, start column and length; a line closes with an end marker carrying the count.
// A character passes the input register, then the classification stage, which writes
// its results into the four-entry result queue; the queue head is offered on the token
// channel.
// Throughput: one character per cycle. A character that yields two results (a closed
// run plus a symbol, or a run plus the end marker) needs two output transfers; the
// held character waits whenever the queue has fewer than two free entries.
// When the receiver stalls, the head result holds and the queue fills; char_stall rises
// once the held character cannot be placed.
// Reset clears the lexer to idle at column zero with the line's count and overflow
// cleared, and empties the queue.
module assembly_line_lexer_core #(
    parameter int MAX_TOKEN_CHARS = 80,
    parameter int MAX_LINE_TOKENS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 char_valid,
    output logic                 char_stall,
    input  asl_pkg::char_item_t  char_item,
    output logic                 token_valid,
    input  logic                 token_stall,
    output asl_pkg::token_item_t token_item
);

    logic                 char_vld_reg, char_vld_next;
    asl_pkg::char_item_t  char_item_reg;
    logic                 room;
    logic                 step;
    asl_pkg::token_push_t push;

    assign step          = char_vld_reg && room;
    assign char_stall    = char_vld_reg && !room;
    assign char_vld_next = char_stall ? char_vld_reg : char_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            char_vld_reg <= 1'b0;
        else
            char_vld_reg <= char_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
            char_item_reg <= char_item;
    end

    asl_lexer #(
        .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS),
        .MAX_LINE_TOKENS (MAX_LINE_TOKENS)
    ) u_lexer (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (char_item_reg),
        .push  (push)
    );

    asl_out_fifo u_out_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .room        (room),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_item  (token_item)
    );

endmodule
